### sv/touch_sample_filter_calibrate_top_assert.svh
`ifndef TOUCH_SAMPLE_FILTER_CALIBRATE_TOP_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_CALIBRATE_TOP_ASSERT_SVH

// check a property on every clock edge outside reset
`define TSFC_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define TSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tsfc_pkg.sv
package tsfc_pkg;

  localparam int SAMPLES_DEF       = 8;
  localparam int TRIM_COUNT_DEF    = 2;
  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 320;

  localparam int READ_W = 12;
  localparam int COEF_W = 32;
  localparam int PROD_W = COEF_W + READ_W + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam int FRAC_W = 16;

  localparam logic [1:0] CMD_PRESSURE = 2'd0;
  localparam logic [1:0] CMD_X        = 2'd1;
  localparam logic [1:0] CMD_Y        = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  localparam logic [2:0] REG_PRESSURE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_COEF_X_FROM_X      = 3'd1;
  localparam logic [2:0] REG_COEF_X_FROM_Y      = 3'd2;
  localparam logic [2:0] REG_OFFSET_X           = 3'd3;
  localparam logic [2:0] REG_COEF_Y_FROM_X      = 3'd4;
  localparam logic [2:0] REG_COEF_Y_FROM_Y      = 3'd5;
  localparam logic [2:0] REG_OFFSET_Y           = 3'd6;
  localparam logic [2:0] REG_RAW_MODE           = 3'd7;

  localparam logic [READ_W-1:0] THRESHOLD_RST = 12'd100;
  localparam logic [COEF_W-1:0] COEF_ONE_RST  = 32'h0001_0000;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] high_byte;
    logic [7:0] low_byte;
  } in_item_t;

  typedef struct packed {
    logic              touched;
    logic [READ_W-1:0] pos_x;
    logic [READ_W-1:0] pos_y;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        index;
    logic [COEF_W-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [READ_W-1:0] pressure_threshold;
    logic [COEF_W-1:0] coef_x_from_x;
    logic [COEF_W-1:0] coef_x_from_y;
    logic [COEF_W-1:0] offset_x;
    logic [COEF_W-1:0] coef_y_from_x;
    logic [COEF_W-1:0] coef_y_from_y;
    logic [COEF_W-1:0] offset_y;
    logic              raw_mode;
  } cfg_regs_t;

  typedef struct packed {
    logic latch_in;
    logic pressure;
    logic insert;
    logic sum_clr;
    logic sum_add;
    logic div1;
    logic div2;
    logic store_x;
    logic set_notouch;
    logic set_raw;
    logic arm_clr;
    logic acc_load;
    logic cal_y;
    logic mul_en;
    logic mul_b;
    logic acc_add;
    logic store_px;
    logic store_py;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       raw_mode;
    logic       below_thr;
    logic       run_full;
    logic       sum_last;
    logic       armed;
    logic       out_free;
  } dp_sts_t;

endpackage

### sv/tsfc_chan_if.sv
interface tsfc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/touch_sample_filter_calibrate_top.sv
// Touch reading filter and calibrator. Each input item is one conversion reply;
// an item that completes no run is accepted, then decoded and placed by sorted
// insert into the sample row, and a pressure item below the threshold then goes on
// to load the output register. The item that completes an x or y run then sums the
// middle samples in the single summing accumulator, followed by the reciprocal
// divide, its correction step and the dispatch; a y run then loads the output
// register in raw mode, or in touch mode, if armed by a pressure item, works out x and
// y on the one shared 32 x 13 multiplier and accumulator before that load. The
// result waits there until taken while the block goes idle; an item that produces a
// result is held back only while the previous one is unread. Configuration writes
// are taken in every cycle; make them only while no item is in flight.
module touch_sample_filter_calibrate_top #(
  parameter int SAMPLES       = tsfc_pkg::SAMPLES_DEF,
  parameter int TRIM_COUNT    = tsfc_pkg::TRIM_COUNT_DEF,
  parameter int SCREEN_WIDTH  = tsfc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tsfc_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsfc_chan_if.sink   in_i,
  tsfc_chan_if.source out_o,
  tsfc_chan_if.sink   cfg_i
);

  tsfc_pkg::cfg_regs_t cfg_regs;
  tsfc_pkg::dp_cmd_t   dp_cmd;
  tsfc_pkg::dp_sts_t   dp_sts;

  tsfc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .regs_o     (cfg_regs)
  );

  tsfc_datapath #(
    .SAMPLES       (SAMPLES),
    .TRIM_COUNT    (TRIM_COUNT),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .cfg_i       (cfg_regs),
    .in_data_i   (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  tsfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (dp_cmd),
    .sts_i      (dp_sts)
  );

endmodule

### sv/tsfc_cfg.sv
module tsfc_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  input  tsfc_pkg::cfg_item_t  wr_data_i,
  output logic                 wr_ready_o,
  output tsfc_pkg::cfg_regs_t  regs_o
);

  tsfc_pkg::cfg_regs_t regs_q, regs_d;

  assign wr_ready_o = 1'b1;
  assign regs_o     = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (wr_valid_i) begin
      unique case (wr_data_i.index)
        tsfc_pkg::REG_PRESSURE_THRESHOLD:
          regs_d.pressure_threshold = wr_data_i.value[tsfc_pkg::READ_W-1:0];
        tsfc_pkg::REG_COEF_X_FROM_X: regs_d.coef_x_from_x = wr_data_i.value;
        tsfc_pkg::REG_COEF_X_FROM_Y: regs_d.coef_x_from_y = wr_data_i.value;
        tsfc_pkg::REG_OFFSET_X:      regs_d.offset_x      = wr_data_i.value;
        tsfc_pkg::REG_COEF_Y_FROM_X: regs_d.coef_y_from_x = wr_data_i.value;
        tsfc_pkg::REG_COEF_Y_FROM_Y: regs_d.coef_y_from_y = wr_data_i.value;
        tsfc_pkg::REG_OFFSET_Y:      regs_d.offset_y      = wr_data_i.value;
        tsfc_pkg::REG_RAW_MODE:      regs_d.raw_mode      = wr_data_i.value[0];
        default: regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.pressure_threshold <= tsfc_pkg::THRESHOLD_RST;
      regs_q.coef_x_from_x      <= tsfc_pkg::COEF_ONE_RST;
      regs_q.coef_x_from_y      <= '0;
      regs_q.offset_x           <= '0;
      regs_q.coef_y_from_x      <= '0;
      regs_q.coef_y_from_y      <= tsfc_pkg::COEF_ONE_RST;
      regs_q.offset_y           <= '0;
      regs_q.raw_mode           <= 1'b0;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

### sv/tsfc_datapath.sv
module tsfc_datapath #(
  parameter int SAMPLES       = tsfc_pkg::SAMPLES_DEF,
  parameter int TRIM_COUNT    = tsfc_pkg::TRIM_COUNT_DEF,
  parameter int SCREEN_WIDTH  = tsfc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tsfc_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tsfc_pkg::dp_cmd_t    cmd_i,
  output tsfc_pkg::dp_sts_t    sts_o,
  input  tsfc_pkg::cfg_regs_t  cfg_i,
  input  tsfc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tsfc_pkg::out_item_t  out_data_o
);

  localparam int RW       = tsfc_pkg::READ_W;
  localparam int IDXW     = $clog2(SAMPLES);
  localparam int TRIM_EFF = (2 * TRIM_COUNT >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM_COUNT;
  localparam int DIVISOR  = SAMPLES - 2 * TRIM_EFF;
  localparam int SUMW     = $clog2(SAMPLES * (1 << RW));
  localparam logic [SUMW:0] RECIP = (SUMW + 1)'((64'd1 << SUMW) / DIVISOR);
  localparam int AW       = tsfc_pkg::ACC_W;
  localparam int PW       = tsfc_pkg::PROD_W;
  localparam int FW       = tsfc_pkg::FRAC_W;
  localparam int VW       = AW - FW;

  logic [1:0]          cmd_q;
  logic [RW-1:0]       rd_q;
  logic [RW-1:0]       samp_q [SAMPLES];
  logic [RW-1:0]       samp_d [SAMPLES];
  logic [SAMPLES-1:0]  gt;
  logic [IDXW-1:0]     count_q, count_d, n_eff;
  logic [1:0]          run_ch_q, run_ch_d;
  logic                armed_q, armed_d;
  logic [RW-1:0]       x_mean_q, x_mean_d;
  logic [IDXW-1:0]     idx_q;
  logic [SUMW-1:0]     sum_q;
  logic [SUMW-1:0]     q0_q;
  logic [2*SUMW:0]     recip_prod;
  logic [SUMW-1:0]     rem;
  logic [RW-1:0]       mean_q;
  logic signed [tsfc_pkg::COEF_W-1:0] coef_sel;
  logic [RW-1:0]       mul_mean;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic                touched_q;
  logic [RW-1:0]       px_q, py_q;
  logic                out_valid_q;
  tsfc_pkg::out_item_t out_q;
  logic                run_full;

  function automatic logic [RW-1:0] clamp_pos(logic signed [AW-1:0] s, logic [RW:0] size);
    logic [VW-1:0] v;
    v = s[AW-1:FW];
    if (s[AW-1]) begin
      clamp_pos = '0;
    end else if (v >= VW'(size)) begin
      clamp_pos = RW'(size - 1'b1);
    end else begin
      clamp_pos = v[RW-1:0];
    end
  endfunction

  // insertion into the ascending run
  always_comb begin
    n_eff = (cmd_q != run_ch_q) ? '0 : count_q;
    for (int j = 0; j < SAMPLES; j++) begin
      gt[j] = (IDXW'(j) < n_eff) && (samp_q[j] > rd_q);
    end
    for (int j = 0; j < SAMPLES; j++) begin
      if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
        samp_d[j] = samp_q[(j > 0) ? j - 1 : 0];
      end else if (gt[j] || IDXW'(j) == n_eff) begin
        samp_d[j] = rd_q;
      end else begin
        samp_d[j] = samp_q[j];
      end
    end
  end

  assign run_full = (n_eff == IDXW'(SAMPLES - 1));

  always_comb begin
    count_d  = count_q;
    run_ch_d = run_ch_q;
    armed_d  = armed_q;
    x_mean_d = x_mean_q;
    if (cmd_i.pressure) begin
      count_d  = '0;
      run_ch_d = tsfc_pkg::CMD_PRESSURE;
      armed_d  = !(rd_q < cfg_i.pressure_threshold);
    end
    if (cmd_i.insert) begin
      count_d  = run_full ? '0 : n_eff + 1'b1;
      run_ch_d = cmd_q;
    end
    if (cmd_i.arm_clr) begin
      armed_d = 1'b0;
    end
    if (cmd_i.store_x) begin
      x_mean_d = mean_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      run_ch_q    <= tsfc_pkg::CMD_PRESSURE;
      armed_q     <= 1'b0;
      x_mean_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      run_ch_q <= run_ch_d;
      armed_q  <= armed_d;
      x_mean_q <= x_mean_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign recip_prod = sum_q * RECIP;
  assign rem        = sum_q - SUMW'(q0_q * SUMW'(DIVISOR));

  always_comb begin
    unique case ({cmd_i.cal_y, cmd_i.mul_b})
      2'b00:   coef_sel = $signed(cfg_i.coef_x_from_x);
      2'b01:   coef_sel = $signed(cfg_i.coef_x_from_y);
      2'b10:   coef_sel = $signed(cfg_i.coef_y_from_x);
      default: coef_sel = $signed(cfg_i.coef_y_from_y);
    endcase
    mul_mean = cmd_i.mul_b ? mean_q : x_mean_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      cmd_q <= in_data_i.command;
      rd_q  <= {in_data_i.high_byte[6:0], in_data_i.low_byte[7:3]};
    end
    if (cmd_i.insert) begin
      samp_q <= samp_d;
    end
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
      idx_q <= IDXW'(TRIM_EFF);
    end else if (cmd_i.sum_add) begin
      sum_q <= sum_q + SUMW'(samp_q[idx_q]);
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.div1) begin
      q0_q <= recip_prod[2*SUMW-1:SUMW];
    end
    if (cmd_i.div2) begin
      mean_q <= (rem >= SUMW'(DIVISOR)) ? RW'(q0_q + 1'b1) : RW'(q0_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= coef_sel * $signed({1'b0, mul_mean});
    end
    if (cmd_i.acc_load) begin
      acc_q <= cmd_i.cal_y ? AW'($signed(cfg_i.offset_y)) : AW'($signed(cfg_i.offset_x));
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + AW'(prod_q);
    end
    if (cmd_i.set_notouch) begin
      touched_q <= 1'b0;
      px_q      <= '0;
      py_q      <= '0;
    end else if (cmd_i.set_raw) begin
      touched_q <= 1'b1;
      px_q      <= x_mean_q;
      py_q      <= mean_q;
    end else begin
      if (cmd_i.store_px) begin
        touched_q <= 1'b1;
        px_q      <= clamp_pos(acc_q, (RW + 1)'(SCREEN_WIDTH));
      end
      if (cmd_i.store_py) begin
        touched_q <= 1'b1;
        py_q      <= clamp_pos(acc_q, (RW + 1)'(SCREEN_HEIGHT));
      end
    end
    if (cmd_i.out_load) begin
      out_q.touched <= touched_q;
      out_q.pos_x   <= px_q;
      out_q.pos_y   <= py_q;
    end
  end

  assign sts_o.command   = cmd_q;
  assign sts_o.raw_mode  = cfg_i.raw_mode;
  assign sts_o.below_thr = rd_q < cfg_i.pressure_threshold;
  assign sts_o.run_full  = run_full;
  assign sts_o.sum_last  = (idx_q == IDXW'(SAMPLES - TRIM_EFF - 1));
  assign sts_o.armed     = armed_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/tsfc_ctrl.sv
`include "touch_sample_filter_calibrate_top_assert.svh"

module tsfc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output tsfc_pkg::dp_cmd_t  cmd_o,
  input  tsfc_pkg::dp_sts_t  sts_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_DIV1 = 4'd3;
  localparam logic [3:0] S_DIV2 = 4'd4;
  localparam logic [3:0] S_POST = 4'd5;
  localparam logic [3:0] S_C0   = 4'd6;
  localparam logic [3:0] S_C1   = 4'd7;
  localparam logic [3:0] S_C2   = 4'd8;
  localparam logic [3:0] S_C3   = 4'd9;
  localparam logic [3:0] S_C4   = 4'd10;
  localparam logic [3:0] S_C5   = 4'd11;
  localparam logic [3:0] S_C6   = 4'd12;
  localparam logic [3:0] S_EMIT = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.command) inside
          tsfc_pkg::CMD_PRESSURE: begin
            if (sts_i.raw_mode) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.pressure = 1'b1;
              if (sts_i.below_thr) begin
                cmd_o.set_notouch = 1'b1;
                state_d           = S_EMIT;
              end else begin
                state_d = S_IDLE;
              end
            end
          end
          tsfc_pkg::CMD_X, tsfc_pkg::CMD_Y: begin
            cmd_o.insert = 1'b1;
            if (sts_i.run_full) begin
              cmd_o.sum_clr = 1'b1;
              state_d       = S_SUM;
            end else begin
              state_d = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SUM: begin
        cmd_o.sum_add = 1'b1;
        if (sts_i.sum_last) begin
          state_d = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd_o.div1 = 1'b1;
        state_d    = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div2 = 1'b1;
        state_d    = S_POST;
      end
      S_POST: begin
        if (sts_i.command == tsfc_pkg::CMD_X) begin
          cmd_o.store_x = 1'b1;
          state_d       = S_IDLE;
        end else if (sts_i.raw_mode) begin
          cmd_o.set_raw = 1'b1;
          state_d       = S_EMIT;
        end else if (!sts_i.armed) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.arm_clr = 1'b1;
          state_d       = S_C0;
        end
      end
      S_C0: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.mul_en   = 1'b1;
        state_d        = S_C1;
      end
      S_C1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_b   = 1'b1;
        cmd_o.acc_add = 1'b1;
        state_d       = S_C2;
      end
      S_C2: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_C3;
      end
      S_C3: begin
        cmd_o.store_px = 1'b1;
        cmd_o.acc_load = 1'b1;
        cmd_o.cal_y    = 1'b1;
        cmd_o.mul_en   = 1'b1;
        state_d        = S_C4;
      end
      S_C4: begin
        cmd_o.cal_y   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_b   = 1'b1;
        cmd_o.acc_add = 1'b1;
        state_d       = S_C5;
      end
      S_C5: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_C6;
      end
      S_C6: begin
        cmd_o.store_py = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TSFC_ASSERT_NEXT(a_accept_decodes, in_valid_i && in_ready_o, state_q == S_DEC, "item not decoded")
  `TSFC_ASSERT_HOLDS(a_load_when_free, !cmd_o.out_load || sts_i.out_free, "output overwritten")
  `TSFC_ASSERT_NEXT(a_sum_ends, state_q == S_SUM && sts_i.sum_last, state_q == S_DIV1, "sum overran")
  `TSFC_ASSERT_HOLDS(a_raw_result_raw, !cmd_o.set_raw || sts_i.raw_mode, "raw result in touch mode")

endmodule

### dv/tb.sv
module tb;
  import tsfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned SETTLE_CYCLES = 40;

  class touch_scoreboard;
    cfg_regs_t regs;
    logic [READ_W-1:0] row [SAMPLES_DEF];
    int unsigned fill;
    logic [1:0] chan;
    logic [READ_W-1:0] x_avg;
    bit armed;
    out_item_t expected_q [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned positions;
    int unsigned misses;

    function new();
      regs = '{pressure_threshold: THRESHOLD_RST, coef_x_from_x: COEF_ONE_RST,
               coef_y_from_y: COEF_ONE_RST, default: '0};
      foreach (row[i]) row[i] = '0;
      fill = 0;
      chan = CMD_PRESSURE;
      x_avg = '0;
      armed = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [COEF_W-1:0] val);
      case (idx)
        REG_PRESSURE_THRESHOLD: regs.pressure_threshold = val[READ_W-1:0];
        REG_COEF_X_FROM_X:      regs.coef_x_from_x = val;
        REG_COEF_X_FROM_Y:      regs.coef_x_from_y = val;
        REG_OFFSET_X:           regs.offset_x = val;
        REG_COEF_Y_FROM_X:      regs.coef_y_from_x = val;
        REG_COEF_Y_FROM_Y:      regs.coef_y_from_y = val;
        REG_OFFSET_Y:           regs.offset_y = val;
        REG_RAW_MODE:           regs.raw_mode = val[0];
        default: ;
      endcase
    endfunction

    function logic [READ_W-1:0] screen_coord(logic [COEF_W-1:0] ca, logic [COEF_W-1:0] cb,
                                             logic [COEF_W-1:0] off, logic [READ_W-1:0] xm,
                                             logic [READ_W-1:0] ym, int size);
      longint acc;
      acc = longint'($signed(ca)) * longint'(xm) + longint'($signed(cb)) * longint'(ym)
            + longint'($signed(off));
      if (acc < 0) return '0;
      acc = acc >>> FRAC_W;
      if (acc >= size) return READ_W'(size - 1);
      return acc[READ_W-1:0];
    endfunction

    // returns 0 when the block ignores the item
    function bit note_input(in_item_t it);
      logic [READ_W-1:0] rd;
      logic [READ_W-1:0] mean;
      int unsigned j;
      int unsigned trim;
      int unsigned sum;
      rd = {it.high_byte[6:0], it.low_byte[7:3]};
      if (it.command == CMD_NONE) return 1'b0;
      if (it.command == CMD_PRESSURE) begin
        if (regs.raw_mode) return 1'b0;
        fill = 0;
        chan = CMD_PRESSURE;
        if (rd < regs.pressure_threshold) begin
          armed = 1'b0;
          expected_q.push_back('{touched: 1'b0, pos_x: '0, pos_y: '0});
        end else begin
          armed = 1'b1;
        end
        return 1'b1;
      end
      if (it.command != chan) fill = 0;
      chan = it.command;
      j = fill;
      while (j > 0 && row[j-1] > rd) begin
        row[j] = row[j-1];
        j--;
      end
      row[j] = rd;
      fill++;
      if (fill < SAMPLES_DEF) return 1'b1;
      fill = 0;
      trim = TRIM_COUNT_DEF;
      if (2 * trim >= SAMPLES_DEF) trim = (SAMPLES_DEF - 1) / 2;
      sum = 0;
      for (int unsigned i = trim; i < SAMPLES_DEF - trim; i++) sum += row[i];
      mean = READ_W'(sum / (SAMPLES_DEF - 2 * trim));
      if (it.command == CMD_X) begin
        x_avg = mean;
      end else if (regs.raw_mode) begin
        expected_q.push_back('{touched: 1'b1, pos_x: x_avg, pos_y: mean});
      end else if (armed) begin
        armed = 1'b0;
        expected_q.push_back('{touched: 1'b1,
          pos_x: screen_coord(regs.coef_x_from_x, regs.coef_x_from_y, regs.offset_x,
                              x_avg, mean, SCREEN_WIDTH_DEF),
          pos_y: screen_coord(regs.coef_y_from_x, regs.coef_y_from_y, regs.offset_y,
                              x_avg, mean, SCREEN_HEIGHT_DEF)});
      end
      return 1'b1;
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: touched %0d pos_x %0d pos_y %0d",
               got.touched, got.pos_x, got.pos_y);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r.touched) positions++;
      else misses++;
      compare_field("touched", exp_r.touched, got.touched);
      compare_field("pos_x", exp_r.pos_x, got.pos_x);
      compare_field("pos_y", exp_r.pos_y, got.pos_y);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned phase_items;
  int unsigned total_items = 0;
  int unsigned phases = 0;
  touch_scoreboard sb = new();

  tsfc_chan_if #(.T(in_item_t))  in_if ();
  tsfc_chan_if #(.T(out_item_t)) out_if ();
  tsfc_chan_if #(.T(cfg_item_t)) cfg_if ();

  touch_sample_filter_calibrate_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    total_items++;
    if (sb.note_input(it)) phase_items++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [COEF_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic write_all(input cfg_regs_t c);
    write_reg(REG_PRESSURE_THRESHOLD, COEF_W'(c.pressure_threshold));
    write_reg(REG_COEF_X_FROM_X, c.coef_x_from_x);
    write_reg(REG_COEF_X_FROM_Y, c.coef_x_from_y);
    write_reg(REG_OFFSET_X, c.offset_x);
    write_reg(REG_COEF_Y_FROM_X, c.coef_y_from_x);
    write_reg(REG_COEF_Y_FROM_Y, c.coef_y_from_y);
    write_reg(REG_OFFSET_Y, c.offset_y);
    write_reg(REG_RAW_MODE, COEF_W'(c.raw_mode));
    cfg_if.valid <= 1'b0;
  endtask

  // hold the input until every expected item has come back, then let the block go idle
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic [1:0] cmd, logic [READ_W-1:0] rd);
    return '{command: cmd, high_byte: {1'($urandom), rd[11:5]},
             low_byte: {rd[4:0], 3'($urandom)}};
  endfunction

  function automatic logic [READ_W-1:0] sample_reading(int unsigned centre);
    int unsigned roll;
    int lo_b;
    int hi_b;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 50) return READ_W'($urandom);
    lo_b = (centre > 64) ? centre - 64 : 0;
    hi_b = (centre + 64 < 4095) ? centre + 64 : 4095;
    return READ_W'($urandom_range(hi_b, lo_b));
  endfunction

  function automatic logic [READ_W-1:0] pressure_reading();
    int unsigned thr;
    thr = sb.regs.pressure_threshold;
    if (thr == 0 || $urandom_range(99) < 80) return READ_W'($urandom_range(4095, thr));
    return READ_W'($urandom_range(thr - 1, 0));
  endfunction

  task automatic touch_sequence();
    int unsigned cx;
    int unsigned cy;
    cx = $urandom_range(4095);
    cy = $urandom_range(4095);
    send_item(make_item(CMD_PRESSURE, pressure_reading()));
    repeat (SAMPLES_DEF) send_item(make_item(CMD_X, sample_reading(cx)));
    repeat (SAMPLES_DEF) send_item(make_item(CMD_Y, sample_reading(cy)));
  endtask

  task automatic broken_sequence();
    logic [1:0] first;
    logic [1:0] second;
    int unsigned cut;
    first  = $urandom_range(1) ? CMD_X : CMD_Y;
    second = (first == CMD_X) ? CMD_Y : CMD_X;
    cut = $urandom_range(SAMPLES_DEF - 1, 1);
    send_item(make_item(CMD_PRESSURE, pressure_reading()));
    repeat (cut) send_item(make_item(first, READ_W'($urandom)));
    repeat (SAMPLES_DEF) send_item(make_item(second, READ_W'($urandom)));
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                           input bit pause);
    int unsigned roll;
    bit paused;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    phase_items = 0;
    paused = 1'b0;
    while (phase_items < PHASE_ITEMS) begin
      if (pause && !paused && phase_items >= PHASE_ITEMS / 2) begin
        settle();
        paused = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 75) begin
        touch_sequence();
      end else if (roll < 87) begin
        broken_sequence();
      end else begin
        repeat ($urandom_range(6, 1))
          send_item('{command: 2'($urandom), high_byte: 8'($urandom),
                      low_byte: 8'($urandom)});
      end
    end
    settle();
    phases++;
  endtask

  function automatic cfg_regs_t cal_random(bit raw);
    cfg_regs_t c;
    c.pressure_threshold = READ_W'($urandom_range(400));
    c.coef_x_from_x = COEF_W'($urandom_range(26000)) - COEF_W'(6000);
    c.coef_x_from_y = COEF_W'($urandom_range(26000)) - COEF_W'(6000);
    c.offset_x      = COEF_W'($urandom_range(32'h0200_0000)) - COEF_W'(32'h0080_0000);
    c.coef_y_from_x = COEF_W'($urandom_range(26000)) - COEF_W'(6000);
    c.coef_y_from_y = COEF_W'($urandom_range(26000)) - COEF_W'(6000);
    c.offset_y      = COEF_W'($urandom_range(32'h0200_0000)) - COEF_W'(32'h0080_0000);
    c.raw_mode      = raw;
    return c;
  endfunction

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item('{command: CMD_PRESSURE, high_byte: 8'h00, low_byte: 8'h00});
    send_item('{command: CMD_NONE, high_byte: 8'hFF, low_byte: 8'hFF});
    send_item('{command: CMD_PRESSURE, high_byte: 8'hFF, low_byte: 8'hFF});
    send_item('{command: CMD_Y, high_byte: 8'h00, low_byte: 8'h00});
    send_item('{command: CMD_Y, high_byte: 8'hFF, low_byte: 8'hFF});
    send_item('{command: CMD_Y, high_byte: 8'h80, low_byte: 8'h07});
    send_item('{command: CMD_Y, high_byte: 8'h7F, low_byte: 8'hF8});
    send_item(make_item(CMD_Y, 12'd2048));
    send_item(make_item(CMD_Y, 12'd1));
    send_item(make_item(CMD_Y, 12'd4094));
    send_item(make_item(CMD_Y, 12'd100));
    repeat (3) send_item(make_item(CMD_X, 12'd4095));
    repeat (SAMPLES_DEF) send_item(make_item(CMD_Y, READ_W'($urandom)));
    run_phase(0, 0, 1'b0);

    write_all(cal_random(1'b0));
    run_phase(71, 0, 1'b1);
    write_all('{12'd4095, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
    run_phase(0, 71, 1'b0);
    write_all('{12'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0});
    run_phase(27, 27, 1'b0);
    write_all(cal_random(1'b1));
    run_phase(0, 0, 1'b0);
    run_phase(27, 27, 1'b1);
    write_all(cal_random(1'b0));
    run_phase(71, 0, 1'b1);
    write_all('{READ_W'($urandom), $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, 1'b0});
    run_phase(0, 71, 1'b0);

    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    $display("Sent %0d items over %0d phases of calibration, raw mode and idling.",
             total_items, phases);
    $display("Checked %0d results: %0d positions, %0d not touched.",
             sb.checked, sb.positions, sb.misses);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
